// ----- hdl/axss_pkg.sv -----
`default_nettype none

package axss_pkg;

    // item kinds carried on s_axis_tuser
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd2;

    localparam int unsigned VAL_W  = 32;   // coordinate width
    localparam int unsigned THR_W  = 16;   // threshold width
    localparam int unsigned OFF_W  = 17;   // snap offset width
    localparam int unsigned MOV_W  = 33;   // source + delta
    localparam int unsigned DIFF_W = 34;   // target - moved source
    localparam int unsigned NSRC   = 3;

    localparam int unsigned IN_TDATA_W  = 32;
    localparam int unsigned IN_TUSER_W  = 2;
    localparam int unsigned OUT_TDATA_W = 120;

    localparam logic [THR_W-1:0] THR_RESET = 16'd2048;

    typedef struct packed {
        logic                    found;
        logic signed [OFF_W-1:0] snap_offset;
        logic signed [VAL_W-1:0] matched_source;
        logic signed [VAL_W-1:0] matched_target;
        logic signed [VAL_W-1:0] adjusted_delta;
        logic                    status;
    } t_result;

    // running best for one source
    typedef struct packed {
        logic                    valid;
        logic        [THR_W-1:0] gap;
        logic signed [OFF_W-1:0] off;
        logic signed [VAL_W-1:0] tgt;
    } t_best;

endpackage

`default_nettype wire

// ----- hdl/axis_snap_search.sv -----
`default_nettype none

// axis_snap_search: one-axis snap search for a dragged selection, signed fixed
// point at 1/1024 unit per LSB. Targets live in a single-port-read RAM of
// TARGET_DEPTH words; a clear word empties it, an add word appends (status set
// and the add dropped when full), a query word carries the drag delta. The query
// walks the stored targets once, one RAM read per cycle, and tests the three
// sources (bound_low, floor midpoint, bound_high) side by side, each keeping its
// own best match; the per-source bests are merged at the end, ties going to the
// earlier source and, within a source, to the smaller target. Every word in gives
// exactly one word out. A clear or add goes from acceptance straight to S_WAIT;
// a query passes through S_PREP, S_SCAN and S_FIN first. A stalled receiver
// holds the block in S_WAIT. A new word is taken while the previous result
// still sits in the output register.
// Configuration is a plain write port and must only be used while idle.

module axis_snap_search #(
    parameter int unsigned TARGET_DEPTH = 256
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    // configuration
    input  wire                                     i_cfg_we,
    input  wire  [axss_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire  [axss_pkg::VAL_W-1:0]              i_cfg_data,
    // input words
    input  wire                                     s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire  [axss_pkg::IN_TDATA_W-1:0]         s_axis_tdata,  // [31:0] value
    input  wire  [axss_pkg::IN_TUSER_W-1:0]         s_axis_tuser,  // [1:0] op
    // result words
    output logic                                    m_axis_tvalid,
    input  wire                                     m_axis_tready,
    // [0] found, [17:1] snap_offset, [49:18] matched_source,
    // [81:50] matched_target, [113:82] adjusted_delta, [114] status, rest zero
    output logic [axss_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

    import axss_pkg::*;

    localparam int unsigned AW = (TARGET_DEPTH > 1) ? $clog2(TARGET_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TARGET_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TARGET_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;   // form moved sources, clear bests
    localparam logic [2:0] S_SCAN = 3'd2;   // read targets, two-stage compare
    localparam logic [2:0] S_FIN  = 3'd3;   // merge per-source bests
    localparam logic [2:0] S_WAIT = 3'd4;   // hand result to output register

    // config registers
    logic signed [VAL_W-1:0] r_bound_low;
    logic signed [VAL_W-1:0] r_bound_high;
    logic        [THR_W-1:0] r_thr;
    logic signed [VAL_W-1:0] r_mid;

    // control
    logic [2:0]    r_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic          r_s1_v;
    logic          r_s2_v;
    logic          r_out_v;

    // payload
    logic signed [VAL_W-1:0] r_val;
    logic signed [MOV_W-1:0] r_moved [NSRC];
    logic                    r_s1_in [NSRC];
    logic        [THR_W-1:0] r_s1_dist [NSRC];
    logic signed [OFF_W-1:0] r_s1_off [NSRC];
    logic signed [VAL_W-1:0] r_s1_t;
    t_best                   r_best [NSRC];
    t_result                 r_pend;
    t_result                 r_out;

    logic                    w_in_acc;
    logic [1:0]              w_op;
    logic signed [VAL_W-1:0] w_val;
    logic                    w_full;
    logic                    w_issue;
    logic                    w_out_free;
    logic                    w_we;
    logic [VAL_W-1:0]        w_rdata;
    logic signed [MOV_W-1:0] w_bsum;
    logic signed [VAL_W-1:0] w_src [NSRC];
    t_result                 w_fin;
    t_result                 w_acc_res;

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_op       = s_axis_tuser[1:0];
    assign w_val      = s_axis_tdata[VAL_W-1:0];
    assign w_full     = (r_count >= DEPTH_C);
    assign w_issue    = (r_state == S_SCAN) && (r_idx < r_count);
    assign w_out_free = !r_out_v || m_axis_tready;
    assign w_we       = w_in_acc && (w_op == OP_ADD) && !w_full;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {5'b0, r_out.status, r_out.adjusted_delta,
                            r_out.matched_target, r_out.matched_source,
                            r_out.snap_offset, r_out.found};

    assign w_bsum = {r_bound_low[VAL_W-1], r_bound_low}
                  + {r_bound_high[VAL_W-1], r_bound_high};
    assign w_src[0] = r_bound_low;
    assign w_src[1] = r_mid;
    assign w_src[2] = r_bound_high;

    axss_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TARGET_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_val),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    // configuration writes; out-of-range index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound_low  <= '0;
            r_bound_high <= '0;
            r_thr        <= THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_BOUND_LOW:  r_bound_low  <= i_cfg_data;
                CFG_BOUND_HIGH: r_bound_high <= i_cfg_data;
                CFG_THRESHOLD:  r_thr        <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // floor midpoint, registered from the bounds
    always_ff @(posedge i_clk) begin
        r_mid <= w_bsum[MOV_W-1:1];
    end

    // result of a clear, add or unused word: all zero but the full flag
    always_comb begin
        w_acc_res        = '0;
        w_acc_res.status = (w_op == OP_ADD) && w_full;
    end

    // merge: smallest distance, earlier source on a tie
    always_comb begin
        logic             any;
        logic [1:0]       sel;
        logic [THR_W-1:0] bd;
        logic signed [MOV_W-1:0] adj;
        any = 1'b0;
        sel = 2'd0;
        bd  = '0;
        for (int s = 0; s < NSRC; s++) begin
            if (r_best[s].valid && (!any || r_best[s].gap < bd)) begin
                any = 1'b1;
                sel = 2'(s);
                bd  = r_best[s].gap;
            end
        end
        adj = {r_val[VAL_W-1], r_val}
            + {{(MOV_W-OFF_W){r_best[sel].off[OFF_W-1]}}, r_best[sel].off};
        w_fin = '0;
        w_fin.adjusted_delta = r_val;
        if (any) begin
            w_fin.found          = 1'b1;
            w_fin.snap_offset    = r_best[sel].off;
            w_fin.matched_source = w_src[sel];
            w_fin.matched_target = r_best[sel].tgt;
            if (adj[MOV_W-1] != adj[MOV_W-2]) begin
                w_fin.adjusted_delta = adj[MOV_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                                    : {1'b0, {(VAL_W-1){1'b1}}};
            end else begin
                w_fin.adjusted_delta = adj[VAL_W-1:0];
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_s1_v <= w_issue;
            r_s2_v <= r_s1_v;
            // loading a new result wins over the current one leaving
            if ((r_state == S_WAIT) && w_out_free) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (w_op == OP_CLEAR) begin
                            r_count <= '0;
                        end else if (w_we) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_state <= (w_op == OP_QUERY) ? S_PREP : S_WAIT;
                    end
                end
                S_PREP: begin
                    r_idx   <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_issue) begin
                        r_idx <= r_idx + 1'b1;
                    end else if (!r_s1_v && !r_s2_v) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_val  <= w_val;
            r_pend <= w_acc_res;
        end

        if (r_state == S_PREP) begin
            for (int s = 0; s < NSRC; s++) begin
                r_moved[s]      <= {w_src[s][VAL_W-1], w_src[s]}
                                 + {r_val[VAL_W-1], r_val};
                r_best[s].valid <= 1'b0;
            end
        end

        // stage 1: distance of the target just read to each moved source
        for (int s = 0; s < NSRC; s++) begin
            logic signed [DIFF_W-1:0] dp;
            logic signed [DIFF_W-1:0] dn;
            logic        [DIFF_W-1:0] ad;
            dp = {{(DIFF_W-VAL_W){w_rdata[VAL_W-1]}}, w_rdata}
               - {r_moved[s][MOV_W-1], r_moved[s]};
            dn = {r_moved[s][MOV_W-1], r_moved[s]}
               - {{(DIFF_W-VAL_W){w_rdata[VAL_W-1]}}, w_rdata};
            ad = dp[DIFF_W-1] ? dn : dp;
            r_s1_in[s]   <= (ad[DIFF_W-1:THR_W] == '0) && (ad[THR_W-1:0] <= r_thr);
            r_s1_dist[s] <= ad[THR_W-1:0];
            r_s1_off[s]  <= dp[OFF_W-1:0];
        end
        r_s1_t <= w_rdata;

        // stage 2: keep the closer, or on equal distance the smaller target
        if (r_s2_v) begin
            for (int s = 0; s < NSRC; s++) begin
                if (r_s1_in[s] && (!r_best[s].valid || r_s1_dist[s] < r_best[s].gap
                    || (r_s1_dist[s] == r_best[s].gap && r_s1_t < r_best[s].tgt))) begin
                    r_best[s].valid <= 1'b1;
                    r_best[s].gap   <= r_s1_dist[s];
                    r_best[s].off   <= r_s1_off[s];
                    r_best[s].tgt   <= r_s1_t;
                end
            end
        end

        if (r_state == S_FIN) begin
            r_pend <= w_fin;
        end

        if (r_state == S_WAIT && w_out_free) begin
            r_out <= r_pend;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/axss_ram.sv -----
`default_nettype none

module axss_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 256
) (
    input  wire                                            i_clk,
    input  wire                                            i_we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   i_waddr,
    input  wire  [WIDTH-1:0]                               i_wdata,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   i_raddr,
    output logic [WIDTH-1:0]                               o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
